### rtl/core/sfcd_pkg.sv
// Shared constants and types for the sensor frame check and decode core.
package sfcd_pkg;

  localparam logic [3:0]  HDR_NIBBLE  = 4'hE;
  localparam logic [7:0]  TRAIL_SHORT = 8'h00;
  localparam logic [7:0]  TRAIL_LONG  = 8'hAA;
  localparam logic [3:0]  POS_FIRST   = 4'd0;
  localparam logic [3:0]  POS_SUM_END = 4'd5;
  localparam logic [3:0]  POS_CAP_END = 4'd7;
  localparam logic [3:0]  POS_LAST    = 4'd9;
  localparam logic [3:0]  POS_IDLE    = 4'd10;
  localparam logic [11:0] TEMP_OFFSET = 12'd400;
  localparam int          QUEUE_DEPTH = 2;

  // Check bits for one finished frame.
  typedef struct packed {
    logic header_ok;
    logic sum_ok;
    logic is_short;
    logic is_long;
    logic xor_match;
  } frame_flags_t;

  // One classified frame: check bits plus bytes 0 to 6.
  typedef struct packed {
    frame_flags_t     flags;
    logic [6:0][7:0]  bytes;
  } frame_rec_t;

endpackage

### rtl/core/sensor_frame_check_decode_core.sv
// Top level of the sensor frame check and decode core.
// Path: the edge that takes byte 9 of a frame writes its result into the frame queue; a pop then
//   moves it into the output register, which raises out_tvalid. A full output register delays the pop.
// Throughput: one byte per cycle; in_tready drops only while the frame queue is full, which
//   takes three unconsumed results (two queued, one in the output register).
// Reset: rst_n synchronous, active low; byte counter idle, sum/XOR clear, queue empty, output
//   register invalid. The byte store is not cleared.
module sensor_frame_check_decode_core #(
  parameter int QUEUE_DEPTH = sfcd_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [0:0]  in_tuser,   // [0] frame_start
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] sensor_id, [8] battery_weak, [20:9] temperature_tenths (signed),
  // [28:21] humidity, [44:29] pressure_tenths, [52:45] checksum_byte, [55:53] zero
  output logic [55:0] out_tdata,
  // [0] frame_valid, [1] short_variant, [2] new_format
  output logic [2:0]  out_tuser
);

  logic                 accept;
  logic                 push;
  logic                 pop;
  logic                 q_not_full;
  logic                 q_not_empty;
  sfcd_pkg::frame_rec_t front_rec;
  sfcd_pkg::frame_rec_t back_rec;

  // Input is taken whenever the queue has room; only byte 9 actually pushes.
  assign in_tready = q_not_full;
  assign accept    = in_tvalid && in_tready;

  // Front: counts bytes, keeps sum/XOR, captures bytes, classifies on byte 9.
  sfcd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .data_byte   (in_tdata),
    .frame_start (in_tuser[0]),
    .push        (push),
    .rec         (front_rec)
  );

  // Decoupling queue of classified frames.
  sfcd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_rec    (front_rec),
    .not_full  (q_not_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .rd_rec    (back_rec)
  );

  // Back: decodes fields and holds the result until the transaction completes.
  sfcd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .rec_avail  (q_not_empty),
    .rec        (back_rec),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Invalid frame results carry all-zero fields.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata == '0 && out_tuser == '0))
    else $error("invalid frame result with nonzero fields");

  // Short variant and new format exclude each other.
  a_variant_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[1] && out_tuser[2]))
    else $error("short variant and new format both set");

  // A popped frame always shows up on the output next cycle.
  a_pop_shows: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_tvalid)
    else $error("popped frame not presented");

  // Queued frame with an empty output register is moved out at once.
  a_no_idle_back: assert property (@(posedge clk) disable iff (!rst_n)
    (q_not_empty && !out_tvalid) |-> pop)
    else $error("back end idle with a queued frame");

endmodule

### rtl/core/sfcd_front.sv
// Front end: byte counting, running sum and XOR, byte capture, frame classification.
module sfcd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  input  logic               frame_start,
  output logic               push,
  output sfcd_pkg::frame_rec_t rec
);

  logic [3:0]      pos_r, pos_nxt, pos_eff;
  logic [7:0]      sum_r, sum_nxt, sum_eff;
  logic [7:0]      xor_r, xor_nxt, xor_eff;
  logic [7:0][7:0] cap_r;
  logic            active;

  always_comb begin
    pos_eff = frame_start ? sfcd_pkg::POS_FIRST : pos_r;
    sum_eff = frame_start ? 8'h00 : sum_r;
    xor_eff = frame_start ? 8'h00 : xor_r;
    active  = accept && (pos_eff < sfcd_pkg::POS_IDLE);
    pos_nxt = pos_r;
    sum_nxt = sum_r;
    xor_nxt = xor_r;
    if (accept && frame_start) begin
      pos_nxt = pos_eff;
      sum_nxt = sum_eff;
      xor_nxt = xor_eff;
    end
    if (active) begin
      pos_nxt = pos_eff + 4'd1;
      if (pos_eff <= sfcd_pkg::POS_SUM_END) begin
        sum_nxt = sum_eff + data_byte;
        xor_nxt = xor_eff ^ data_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= sfcd_pkg::POS_IDLE;
      sum_r <= 8'h00;
      xor_r <= 8'h00;
    end else begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
      xor_r <= xor_nxt;
    end
  end

  // capture store: undefined until written, no reset
  always_ff @(posedge clk) begin
    if (active && (pos_eff <= sfcd_pkg::POS_CAP_END)) begin
      cap_r[pos_eff[2:0]] <= data_byte;
    end
  end

  assign push = active && (pos_eff == sfcd_pkg::POS_LAST);

  always_comb begin
    rec.flags.header_ok = (cap_r[0][7:4] == sfcd_pkg::HDR_NIBBLE);
    rec.flags.sum_ok    = (sum_r == cap_r[6]);
    rec.flags.is_short  = (data_byte == sfcd_pkg::TRAIL_SHORT);
    rec.flags.is_long   = (data_byte == sfcd_pkg::TRAIL_LONG);
    rec.flags.xor_match = ({xor_r[3:0], xor_r[7:4]} == cap_r[7]);
    rec.bytes           = cap_r[6:0];
  end

endmodule

### rtl/core/sfcd_queue.sv
// Short queue of classified frames between front and back end.
module sfcd_queue #(
  parameter int DEPTH = sfcd_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  sfcd_pkg::frame_rec_t wr_rec,
  output logic                 not_full,
  input  logic                 pop,
  output logic                 not_empty,
  output sfcd_pkg::frame_rec_t rd_rec
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sfcd_pkg::frame_rec_t slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign not_full  = (count_r != CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign rd_rec    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_rec;
    end
  end

endmodule

### rtl/core/sfcd_back.sv
// Back end: field decode of a classified frame into the output register.
module sfcd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rec_avail,
  input  sfcd_pkg::frame_rec_t rec,
  output logic                 pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [55:0]          out_tdata,
  output logic [2:0]           out_tuser
);

  logic        valid_r;
  logic [55:0] data_r, data_nxt;
  logic [2:0]  user_r, user_nxt;
  logic        ok;
  logic [10:0] raw_temp;
  logic [11:0] temp;

  assign pop = rec_avail && (!valid_r || out_tready);

  always_comb begin
    ok = rec.flags.header_ok && rec.flags.sum_ok &&
         (rec.flags.is_short || rec.flags.is_long);
    raw_temp = {rec.bytes[1][2:0], rec.bytes[2]};
    temp     = {1'b0, raw_temp} - sfcd_pkg::TEMP_OFFSET;
    data_nxt = '0;
    user_nxt = '0;
    if (ok) begin
      user_nxt = {rec.flags.is_long && rec.flags.xor_match, rec.flags.is_short, 1'b1};
      data_nxt = {3'b000, rec.bytes[6], rec.bytes[4], rec.bytes[5], rec.bytes[3], temp,
                  rec.bytes[1][3], rec.bytes[0][3:0], rec.bytes[1][7:4]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data_r <= data_nxt;
      user_r <= user_nxt;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;

endmodule

### verif/sfcd_decode_checker.sv
// Checker for the sensor frame decoder: tracks input bytes, predicts decoded frames, compares.
`timescale 1ns / 100ps

module sfcd_decode_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [0:0]  in_tuser,   // [0] frame_start
  input  logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] sensor_id, [8] battery_weak, [20:9] temperature_tenths,
  // [28:21] humidity, [44:29] pressure_tenths, [52:45] checksum_byte, [55:53] zero
  input  logic [55:0] out_tdata,
  // [0] frame_valid, [1] short_variant, [2] new_format
  input  logic [2:0]  out_tuser,
  output int          mismatch_count,
  output int          frames_pending,
  output int          reports_checked,
  output int          valid_reports,
  output int          short_reports,
  output int          new_format_reports
);

  // One decoded frame; temperature kept as raw 12-bit two's complement.
  typedef struct packed {
    logic        frame_valid;
    logic        short_variant;
    logic        new_format;
    logic [7:0]  sensor_id;
    logic        battery_weak;
    logic [11:0] temp_tenths;
    logic [7:0]  humidity;
    logic [15:0] pressure_tenths;
    logic [7:0]  checksum_byte;
  } frame_report_t;

  frame_report_t expected_reports[$];

  // Decoder state mirror
  logic [3:0] byte_pos;
  logic [7:0] sum_acc;
  logic [7:0] xor_acc;
  logic [7:0] frame_store [8];

  task automatic track_frame_byte(input logic [7:0] d, input logic start);
    frame_report_t rep;
    logic [7:0]    swapped;
    logic [10:0]   raw_temp;
    logic          trail_short;
    logic          trail_long;
    if (start) begin
      byte_pos = sfcd_pkg::POS_FIRST;
      sum_acc  = '0;
      xor_acc  = '0;
    end
    if (byte_pos < sfcd_pkg::POS_IDLE) begin
      if (byte_pos <= sfcd_pkg::POS_SUM_END) begin
        sum_acc = sum_acc + d;
        xor_acc = xor_acc ^ d;
      end
      if (byte_pos <= sfcd_pkg::POS_CAP_END) frame_store[byte_pos[2:0]] = d;
      if (byte_pos == sfcd_pkg::POS_LAST) begin
        rep         = '0;
        swapped     = {xor_acc[3:0], xor_acc[7:4]};
        trail_short = (d == sfcd_pkg::TRAIL_SHORT);
        trail_long  = (d == sfcd_pkg::TRAIL_LONG);
        if (frame_store[0][7:4] == sfcd_pkg::HDR_NIBBLE && sum_acc == frame_store[6] &&
            (trail_short || trail_long)) begin
          raw_temp            = {frame_store[1][2:0], frame_store[2]};
          rep.frame_valid     = 1'b1;
          rep.short_variant   = trail_short;
          rep.new_format      = trail_long && (swapped == frame_store[7]);
          rep.sensor_id       = {frame_store[0][3:0], frame_store[1][7:4]};
          rep.battery_weak    = frame_store[1][3];
          rep.temp_tenths     = {1'b0, raw_temp} - sfcd_pkg::TEMP_OFFSET;
          rep.humidity        = frame_store[3];
          rep.pressure_tenths = {frame_store[4], frame_store[5]};
          rep.checksum_byte   = frame_store[6];
        end
        expected_reports.push_back(rep);
      end
      byte_pos = byte_pos + 4'd1;
    end
  endtask

  task automatic compare_field(input string fname, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fname, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_report();
    frame_report_t want;
    if (expected_reports.size() == 0) begin
      $display("%0t: result with nothing expected, expected none, actual tdata=0x%h tuser=0x%h",
               $time, out_tdata, out_tuser);
      mismatch_count++;
    end else begin
      want = expected_reports.pop_front();
      reports_checked++;
      if (want.frame_valid) valid_reports++;
      if (want.short_variant) short_reports++;
      if (want.new_format) new_format_reports++;
      compare_field("frame_valid",        want.frame_valid,     out_tuser[0]);
      compare_field("short_variant",      want.short_variant,   out_tuser[1]);
      compare_field("new_format",         want.new_format,      out_tuser[2]);
      compare_field("sensor_id",          want.sensor_id,       out_tdata[7:0]);
      compare_field("battery_weak",       want.battery_weak,    out_tdata[8]);
      compare_field("temperature_tenths", want.temp_tenths,     out_tdata[20:9]);
      compare_field("humidity",           want.humidity,        out_tdata[28:21]);
      compare_field("pressure_tenths",    want.pressure_tenths, out_tdata[44:29]);
      compare_field("checksum_byte",      want.checksum_byte,   out_tdata[52:45]);
      compare_field("tdata pad",          0,                    out_tdata[55:53]);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      byte_pos = sfcd_pkg::POS_IDLE;
      sum_acc  = '0;
      xor_acc  = '0;
      expected_reports.delete();
    end else begin
      // drain first: a result never stems from the byte taken at this edge
      if (out_tvalid && out_tready) check_report();
      if (in_tvalid && in_tready) track_frame_byte(in_tdata, in_tuser[0]);
    end
    frames_pending <= expected_reports.size();
  end

endmodule

### verif/sensor_frame_check_decode_core_tb.sv
// Testbench top for the sensor frame check and decode core: stimulus, idling and verdict.
`timescale 1ns / 100ps

module sensor_frame_check_decode_core_tb;

  // Generous cycle ceiling; the slowest legal run stays far below it.
  localparam int CYCLE_LIMIT     = 300000;
  localparam int PHASE_BYTES     = 220;   // input bytes per idle/stall mix, ~900 total
  localparam int HOLD_OFF_CYCLES = 400;   // long receiver stall to back up the frame queue
  localparam int HOLD_OFF_FRAMES = 15;
  localparam int DRAIN_CYCLES    = 16;    // margin after draining to catch stray results

  // Frame shapes the generator can build
  typedef enum int {
    FRAME_SHORT,        // trailer 0x00
    FRAME_LONG_NEW,     // trailer 0xAA, swapped XOR byte matches
    FRAME_LONG_OLD,     // trailer 0xAA, XOR byte off
    FRAME_BAD_SUM,
    FRAME_BAD_HEADER,
    FRAME_BAD_TRAILER,
    FRAME_ABORTED       // cut short by the next frame_start
  } frame_kind_t;

  typedef logic [9:0][7:0] frame_bytes_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] data_byte
  logic [0:0]  in_tuser;   // [0] frame_start
  logic        out_tvalid;
  logic        out_tready;
  // [7:0] sensor_id, [8] battery_weak, [20:9] temperature_tenths,
  // [28:21] humidity, [44:29] pressure_tenths, [52:45] checksum_byte, [55:53] zero
  logic [55:0] out_tdata;
  // [0] frame_valid, [1] short_variant, [2] new_format
  logic [2:0]  out_tuser;

  int mismatch_count;
  int frames_pending;
  int reports_checked;
  int valid_reports;
  int short_reports;
  int new_format_reports;

  // Idle/stall knobs, in percent per cycle
  int src_idle_pct;
  int sink_stall_pct;
  int sink_hold_left;
  int in_bytes_sent;
  int cycle_count;

  sensor_frame_check_decode_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  sfcd_decode_checker checker_i (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_tvalid          (in_tvalid),
    .in_tready          (in_tready),
    .in_tdata           (in_tdata),
    .in_tuser           (in_tuser),
    .out_tvalid         (out_tvalid),
    .out_tready         (out_tready),
    .out_tdata          (out_tdata),
    .out_tuser          (out_tuser),
    .mismatch_count     (mismatch_count),
    .frames_pending     (frames_pending),
    .reports_checked    (reports_checked),
    .valid_reports      (valid_reports),
    .short_reports      (short_reports),
    .new_format_reports (new_format_reports)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: a pending hold-off wins, otherwise random stalls; updated on falling edges.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold_left > 0) begin
        out_tready <= 1'b0;
        sink_hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Watchdog: only ends the run if the main sequence never gets there.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d results still outstanding",
             cycle_count, frames_pending);
    $display("CHECKS FAILED");
    $finish;
  end

  // Offer one byte; returns on the falling edge after the transaction.
  task automatic push_byte(input logic [7:0] value, input logic start);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tuser  <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    in_bytes_sent++;
    @(negedge clk);
  endtask

  // Biased toward the field extremes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(15))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Fill checksum, XOR byte, spare byte and trailer from bytes 0..5 per frame kind.
  function automatic frame_bytes_t finish_frame(input frame_bytes_t fb, input frame_kind_t kind);
    logic [7:0] sum_v;
    logic [7:0] xor_v;
    logic [7:0] swapped;
    sum_v = '0;
    xor_v = '0;
    for (int i = 0; i <= 5; i++) begin
      sum_v = sum_v + fb[i];
      xor_v = xor_v ^ fb[i];
    end
    swapped = {xor_v[3:0], xor_v[7:4]};
    fb[6] = sum_v;
    fb[7] = 8'($urandom);
    fb[8] = 8'($urandom);
    fb[9] = $urandom_range(1) ? sfcd_pkg::TRAIL_SHORT : sfcd_pkg::TRAIL_LONG;
    case (kind)
      FRAME_SHORT: fb[9] = sfcd_pkg::TRAIL_SHORT;
      FRAME_LONG_NEW: begin
        fb[9] = sfcd_pkg::TRAIL_LONG;
        fb[7] = swapped;
      end
      FRAME_LONG_OLD: begin
        fb[9] = sfcd_pkg::TRAIL_LONG;
        fb[7] = swapped ^ 8'($urandom_range(1, 255));
      end
      FRAME_BAD_SUM: fb[6] = sum_v ^ 8'($urandom_range(1, 255));
      FRAME_BAD_TRAILER: begin
        do fb[9] = 8'($urandom);
        while (fb[9] == sfcd_pkg::TRAIL_SHORT || fb[9] == sfcd_pkg::TRAIL_LONG);
      end
      default: ;
    endcase
    return fb;
  endfunction

  function automatic frame_bytes_t build_frame(input frame_kind_t kind);
    frame_bytes_t fb;
    for (int i = 0; i <= 5; i++) fb[i] = pick_byte();
    fb[0][7:4] = sfcd_pkg::HDR_NIBBLE;
    if (kind == FRAME_BAD_HEADER) begin
      do fb[0][7:4] = 4'($urandom); while (fb[0][7:4] == sfcd_pkg::HDR_NIBBLE);
    end
    return finish_frame(fb, kind);
  endfunction

  // Send the first `keep` bytes, then `trailing` bytes the block should ignore.
  task automatic offer_frame(input frame_bytes_t fb, input int keep, input int trailing);
    for (int i = 0; i < keep; i++) push_byte(fb[i], i == 0);
    repeat (trailing) push_byte(8'($urandom), 1'b0);
  endtask

  // Mostly well-formed frames with random content, the rest broken or cut short.
  task automatic offer_random_frame();
    frame_kind_t kind;
    frame_bytes_t fb;
    int pick;
    int keep;
    int trailing;
    pick = $urandom_range(99);
    if (pick < 30)      kind = FRAME_SHORT;
    else if (pick < 55) kind = FRAME_LONG_NEW;
    else if (pick < 70) kind = FRAME_LONG_OLD;
    else if (pick < 78) kind = FRAME_BAD_SUM;
    else if (pick < 85) kind = FRAME_BAD_HEADER;
    else if (pick < 92) kind = FRAME_BAD_TRAILER;
    else                kind = FRAME_ABORTED;
    fb       = build_frame(kind);
    keep     = (kind == FRAME_ABORTED) ? $urandom_range(1, 9) : 10;
    trailing = (kind != FRAME_ABORTED && $urandom_range(4) == 0) ? $urandom_range(1, 3) : 0;
    offer_frame(fb, keep, trailing);
  endtask

  initial begin
    frame_bytes_t fb;
    int src_mix [4];
    int sink_mix [4];
    int phase_start;
    // idle/stall mixes: none, sender idle, receiver stalls, both
    src_mix  = '{0, 88, 0, 24};
    sink_mix = '{0, 0, 88, 24};
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    sink_hold_left = 0;
    in_bytes_sent  = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // --- directed ---
    // bytes with no frame_start while idle: dropped, no result
    push_byte(8'hE5, 1'b0);
    push_byte(8'h00, 1'b0);
    // frame restarted after 4 bytes: no result for it
    fb = build_frame(FRAME_SHORT);
    offer_frame(fb, 4, 0);
    // short variant, all-ones fields: ID 0xFF, battery flag set, temp +1647, pressure 0xFFFF
    fb = '0;
    fb[0] = 8'hEF;
    fb[1] = 8'hFF;
    fb[2] = 8'hFF;
    fb[3] = 8'hFF;
    fb[4] = 8'hFF;
    fb[5] = 8'hFF;
    offer_frame(finish_frame(fb, FRAME_SHORT), 10, 1);
    // long new-format frame, all-zero fields: temp -400
    fb = '0;
    fb[0] = 8'hE0;
    offer_frame(finish_frame(fb, FRAME_LONG_NEW), 10, 0);

    // --- random, one pass per idle/stall mix ---
    for (int p = 0; p < 4; p++) begin
      src_idle_pct   = src_mix[p];
      sink_stall_pct = sink_mix[p];
      phase_start    = in_bytes_sent;
      if (p == 0) begin
        // receiver holds off while bytes keep coming: queue fills, in_tready drops
        sink_hold_left = HOLD_OFF_CYCLES;
        repeat (HOLD_OFF_FRAMES) offer_random_frame();
      end
      while (in_bytes_sent - phase_start < PHASE_BYTES) offer_random_frame();
    end
    in_tvalid <= 1'b0;

    // drain, then watch a little longer for stray results
    sink_stall_pct = 0;
    while (frames_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d input bytes across four idle/stall mixes and a long output hold-off,",
             in_bytes_sent);
    $display("%0d decoded results compared: %0d valid, %0d short variant, %0d new format.",
             reports_checked, valid_reports, short_reports, new_format_reports);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
